FILE: src/pfcc_pkg.sv
// pfcc_pkg: shared constants, types and codes of the prime factor count classifier
// used by pfcc_divider and prime_factor_count_classifier_unit; no dependencies
`timescale 1ns / 1ps

package pfcc_pkg;

    localparam int VALUE_BITS   = 48;
    localparam int DIV_BITS     = VALUE_BITS / 2 + 1;
    localparam int CNT_BITS     = $clog2(VALUE_BITS);
    localparam int VERDICT_BITS = 2;
    localparam int S_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((VERDICT_BITS + VALUE_BITS + 7) / 8) * 8;

    localparam logic [VERDICT_BITS-1:0] VERDICT_ONE_OR_PRIME = 2'd0;
    localparam logic [VERDICT_BITS-1:0] VERDICT_TWO_FACTORS  = 2'd1;
    localparam logic [VERDICT_BITS-1:0] VERDICT_MORE_FACTORS = 2'd2;

    localparam logic [1:0] FACTOR_COUNT_MAX = 2'd3;
    localparam logic [DIV_BITS-1:0] FIRST_DIVISOR = DIV_BITS'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_TAIL,
        ST_MUL,
        ST_OUT
    } pfcc_state_t;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [DIV_BITS-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIV_BITS-1:0]   remainder;
    } div_rsp_t;

endpackage

FILE: src/pfcc_divider.sv
// pfcc_divider: restoring radix-2 divider, one quotient bit per cycle
// depends on pfcc_pkg for widths and the request/response structs
`timescale 1ns / 1ps

module pfcc_divider
    import pfcc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIV_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]   dsr_reg, dsr_next;

    logic [DIV_BITS:0]   partial;
    logic [DIV_BITS+1:0] diff;
    logic                fits;

    assign partial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff    = {1'b0, partial} - {2'b00, dsr_reg};
    assign fits    = ~diff[DIV_BITS+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? diff[DIV_BITS-1:0] : partial[DIV_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_remainder_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < dsr_reg)
        else $error("divider remainder not below divisor");

endmodule

FILE: src/prime_factor_count_classifier_unit.sv
// prime_factor_count_classifier_unit: top level, trial division sequencer around
// one shared divider; depends on pfcc_pkg and pfcc_divider
`timescale 1ns / 1ps
//
// Classifies a positive integer by the number of its prime factors, counted
// with multiplicity, found by trial division with divisors 2, 3, 4, ...
//   s_ channel: one word carries the value in s_tdata.
//   m_ channel: one word per value, verdict and move in m_tdata.
//   verdict 0: one or prime; 1: exactly two prime factors; 2: three or more,
//   and move is then the product of the two smallest prime factors (else 0).
// Every trial divide runs in the shared restoring divider, one quotient bit
// a cycle. The divides for one value are the divisors tried up to the
// square root of the cofactor plus one per factor found, at most about
// 2^24 divides for 48-bit values. s_tready is high only while no value
// is being factored; the finished word sits in an output register, so a
// new value is taken while it waits. If m_tready stays low, the next
// result is held back until the output register frees up. Reset clears
// the sequencer and the output valid.

module prime_factor_count_classifier_unit
    import pfcc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // value, zero padded
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata    // verdict, move, zero padded
);

    pfcc_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]     div_reg, div_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [DIV_BITS-1:0]     first_reg, first_next;
    logic [DIV_BITS-1:0]     second_reg, second_next;
    logic                    repeat_reg, repeat_next;
    logic [VALUE_BITS-1:0]   prod_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [VERDICT_BITS-1:0] out_verdict_reg, out_verdict_next;
    logic [VALUE_BITS-1:0]   out_move_reg, out_move_next;

    logic [2*DIV_BITS-1:0]   prod_full;
    logic                    accept;
    logic                    search_over;
    logic                    out_free;
    logic                    div_start;

    div_req_t div_req;
    div_rsp_t div_rsp;

    pfcc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign accept      = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign search_over = (cnt_reg == FACTOR_COUNT_MAX)
                      || (!repeat_reg && (VALUE_BITS'(div_reg) > div_rsp.quotient));
    assign prod_full   = first_reg * second_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = search_over ? ST_TAIL : ST_DIV_START;
                end
            end
            ST_TAIL:      state_next = ST_MUL;
            ST_MUL:       state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:      s_tready  = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            default: begin
                s_tready  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = rem_reg;
    assign div_req.divisor  = div_reg;

    // datapath
    always_comb begin
        rem_next         = rem_reg;
        div_next         = div_reg;
        cnt_next         = cnt_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        repeat_next      = repeat_reg;
        out_valid_next   = out_valid_reg;
        out_verdict_next = out_verdict_reg;
        out_move_next    = out_move_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            rem_next    = s_tdata[VALUE_BITS-1:0];
            div_next    = FIRST_DIVISOR;
            cnt_next    = '0;
            first_next  = '0;
            second_next = '0;
            repeat_next = 1'b0;
        end

        if (state_reg == ST_DIV_WAIT && div_rsp.done && !search_over) begin
            if (div_rsp.remainder == '0) begin
                if (cnt_reg == 2'd0) begin
                    first_next = div_reg;
                end
                if (cnt_reg == 2'd1) begin
                    second_next = div_reg;
                end
                cnt_next    = cnt_reg + 2'd1;
                rem_next    = div_rsp.quotient;
                repeat_next = 1'b1;
            end else begin
                div_next    = div_reg + 1'b1;
                repeat_next = 1'b0;
            end
        end

        // leftover cofactor above one is the last prime factor
        if (state_reg == ST_TAIL && cnt_reg != FACTOR_COUNT_MAX
                && rem_reg > VALUE_BITS'(1)) begin
            cnt_next = cnt_reg + 2'd1;
        end

        if (state_reg == ST_OUT && out_free) begin
            out_valid_next = 1'b1;
            case (cnt_reg)
                2'd0, 2'd1: begin
                    out_verdict_next = VERDICT_ONE_OR_PRIME;
                    out_move_next    = '0;
                end
                2'd2: begin
                    out_verdict_next = VERDICT_TWO_FACTORS;
                    out_move_next    = '0;
                end
                default: begin
                    out_verdict_next = VERDICT_MORE_FACTORS;
                    out_move_next    = prod_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            repeat_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            repeat_reg    <= repeat_next;
            out_valid_reg <= out_valid_next;
        end
        rem_reg         <= rem_next;
        div_reg         <= div_next;
        first_reg       <= first_next;
        second_reg      <= second_next;
        prod_reg        <= prod_full[VALUE_BITS-1:0];
        out_verdict_reg <= out_verdict_next;
        out_move_reg    <= out_move_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'({out_move_reg, out_verdict_reg});

    a_count_holds_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == FACTOR_COUNT_MAX) && !accept |=> cnt_reg == FACTOR_COUNT_MAX)
        else $error("factor count left its maximum without a new word");

    a_divisor_at_least_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_START || state_reg == ST_DIV_WAIT) |-> div_reg >= FIRST_DIVISOR)
        else $error("trial divisor below two");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_verdict_reg != 2'd3)
        else $error("unused verdict code on output");

    a_move_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_verdict_reg != VERDICT_MORE_FACTORS |-> out_move_reg == '0)
        else $error("move nonzero without three factors");

    a_wait_has_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV_START |=> div_rsp.busy)
        else $error("divider not running after start");

endmodule

FILE: test/pfcc_verdict_checker.sv
// pfcc_verdict_checker: watches both stream channels of the prime factor count
// classifier, predicts each result word from the accepted value and compares them
// depends on pfcc_pkg
`timescale 1ns / 1ps

module pfcc_verdict_checker
    import pfcc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // value, zero padded
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_BITS-1:0] m_tdata,   // verdict, move, zero padded
    output int                      fail_count,
    output int                      pending
);

    localparam int PAD_BITS = M_TDATA_BITS - VALUE_BITS - VERDICT_BITS;

    typedef struct packed {
        logic [PAD_BITS-1:0]     pad;
        logic [VALUE_BITS-1:0]   move;
        logic [VERDICT_BITS-1:0] verdict;
    } verdict_word_t;

    verdict_word_t expected_words [$];
    int fails = 0;
    int waiting = 0;

    assign fail_count = fails;
    assign pending    = waiting;

    // trial division, stopping once three prime factors are known
    function automatic verdict_word_t classify_value(input logic [VALUE_BITS-1:0] value);
        logic [63:0]   cofactor;
        logic [63:0]   trial;
        logic [63:0]   lowest;
        logic [63:0]   next_lowest;
        logic [63:0]   product;
        int unsigned   found;
        verdict_word_t word;
        cofactor    = 64'(value);
        lowest      = '0;
        next_lowest = '0;
        found       = 0;
        for (trial = 64'(FIRST_DIVISOR);
             found < FACTOR_COUNT_MAX && trial <= cofactor / trial;
             trial++) begin
            while (found < FACTOR_COUNT_MAX && cofactor % trial == 0) begin
                if (found == 0)
                    lowest = trial;
                else if (found == 1)
                    next_lowest = trial;
                found++;
                cofactor = cofactor / trial;
            end
        end
        // what is left over is itself prime
        if (found < FACTOR_COUNT_MAX && cofactor > 1) begin
            if (found == 0)
                lowest = cofactor;
            else if (found == 1)
                next_lowest = cofactor;
            found++;
        end
        word = '0;
        if (found <= 1) begin
            word.verdict = VERDICT_ONE_OR_PRIME;
        end else if (found == 2) begin
            word.verdict = VERDICT_TWO_FACTORS;
        end else begin
            word.verdict = VERDICT_MORE_FACTORS;
            product      = lowest * next_lowest;
            word.move    = product[VALUE_BITS-1:0];
        end
        return word;
    endfunction

    always @(posedge aclk) begin : watch_channels
        verdict_word_t seen;
        verdict_word_t want;
        int            errs;
        errs = 0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen = verdict_word_t'(m_tdata);
                if (expected_words.size() == 0) begin
                    $error("result word with no value pending: %h", m_tdata);
                    errs++;
                end else begin
                    want = expected_words.pop_front();
                    if (seen.verdict !== want.verdict) begin
                        $error("verdict mismatch: expected %0d, got %0d",
                               want.verdict, seen.verdict);
                        errs++;
                    end
                    if (seen.move !== want.move) begin
                        $error("move mismatch: expected %0d, got %0d", want.move, seen.move);
                        errs++;
                    end
                    if (seen.pad !== want.pad) begin
                        $error("pad mismatch: expected %h, got %h", want.pad, seen.pad);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_words.insert(expected_words.size(),
                                      classify_value(s_tdata[VALUE_BITS-1:0]));
        end
        fails   <= fails + errs;
        waiting <= expected_words.size();
    end

endmodule

FILE: test/testbench.sv
// testbench: drives values into prime_factor_count_classifier_unit under random
// sender and receiver idling; pfcc_verdict_checker predicts and compares results
// depends on pfcc_pkg, prime_factor_count_classifier_unit and pfcc_verdict_checker
`timescale 1ns / 1ps

module testbench;
    import pfcc_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [63:0] VALUE_TOP = 64'({VALUE_BITS{1'b1}});

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;

    int fail_count;
    int pending;
    int send_idle_pct = 31;
    int recv_idle_pct = 48;
    int stalled_cycles = 0;

    logic [VALUE_BITS-1:0] directed_values [] = '{
        48'd0, 48'd1, 48'd2, 48'd3, 48'd4, 48'd6, 48'd8, 48'd9, 48'd12, 48'd25,
        48'd27, 48'd30, 48'd49, 48'd1001, 48'd16383, 48'd65521, 48'd65535,
        48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFC,
        48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555
    };

    prime_factor_count_classifier_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pfcc_verdict_checker checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint unsigned draw_prime(input int unsigned hi);
        int unsigned n;
        bit          composite;
        do begin
            n = $urandom_range(hi, 2);
            composite = 1'b0;
            for (int unsigned k = 2; k * k <= n; k++)
                if (n % k == 0)
                    composite = 1'b1;
        end while (composite);
        return n;
    endfunction

    // every kind of value is shaped so that factoring ends after a few hundred divides
    function automatic logic [VALUE_BITS-1:0] draw_value();
        int unsigned pick;
        logic [63:0] base;
        logic [63:0] span;
        pick = $urandom_range(9);
        if (pick < 3)
            return VALUE_BITS'($urandom_range(16383));
        if (pick < 7) begin
            // three small factors times a wide random cofactor
            base = 64'($urandom_range(40, 2) * $urandom_range(40, 2) * $urandom_range(40, 2));
            span = VALUE_TOP / base;
            return VALUE_BITS'(base * ({$urandom, $urandom} % span + 1));
        end
        return VALUE_BITS'(draw_prime(250) * draw_prime(20000));
    endfunction

    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'(value);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_values[i])
            send_value(directed_values[i]);
        repeat (26) send_value(draw_value());

        send_idle_pct = 48;
        recv_idle_pct = 31;
        repeat (26) send_value(draw_value());

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (26) send_value(draw_value());

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
